### design/grid_disk_obstacle_check_assert.svh
// Assertion macros used by the checker file of grid_disk_obstacle_check.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef GRID_DISK_OBSTACLE_CHECK_ASSERT_SVH
`define GRID_DISK_OBSTACLE_CHECK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GDOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GDOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gdoc_pkg.sv
// Package of the occupancy grid disk check: widths, register indexes,
// reset values and the divider request/response types. No dependencies.
package gdoc_pkg;

  localparam int unsigned GridCells = 65536;
  localparam int unsigned GridAw    = $clog2(GridCells);
  localparam int unsigned MaxReach  = 32;

  localparam int unsigned CellW  = 8;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RadW   = 10;
  localparam int unsigned MapW   = 9;
  localparam int unsigned LevelW = 7;
  localparam int unsigned ValW   = 8;
  localparam int unsigned IndexW = 16;

  localparam int unsigned ReachW = $clog2(MaxReach + 1);
  localparam int unsigned OffsW  = ReachW + 1;
  localparam int unsigned DivW   = CoordW + 1;
  localparam int unsigned GridW  = DivW + 1;
  localparam int unsigned MetW   = OffsW + CellW;
  localparam int unsigned SqW    = 2 * MetW;
  localparam int unsigned IdxW   = 2 * MapW;
  localparam int unsigned R2W    = 2 * RadW;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgCellSize = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginY  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMapWidth = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMapHght  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLevel    = 3'd5;

  localparam logic [CellW-1:0]  ResetCellSize = 8'd26;
  localparam logic [MapW-1:0]   ResetMapDim   = 9'd256;
  localparam logic [LevelW-1:0] ResetLevel    = 7'd50;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [CellW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### design/gdoc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gdoc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/gdoc_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on gdoc_pkg for widths and the request/response structs.
module gdoc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdoc_pkg::div_req_t req_i,
  output gdoc_pkg::div_rsp_t rsp_o
);
  import gdoc_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CellW-1:0] rem_q, rem_d;
  logic [CellW-1:0] dvs_q, dvs_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [CellW:0]   trial;

  assign trial = {rem_q, quo_q[DivW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CellW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[CellW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### design/grid_disk_obstacle_check.sv
// Top level of the occupancy grid disk check: grid memory, sequencer, scan pipeline.
// Depends on gdoc_pkg, gdoc_ram and gdoc_div.
//
// Usage: a beat is taken when start_i is high and busy_o low. A write beat
// (kind_i = 0) stores cell_value_i at cell_index_i, gives no result and
// leaves busy_o low, so loads may arrive every cycle while idle. A query
// beat (kind_i = 1) raises busy_o; the answer appears on obstacle_hit_o for
// exactly one cycle with result_valid_o, the cycle in which busy_o drops,
// and must be taken then, since the receiver cannot hold it. A query works
// out the centre column, centre row and reach in turn, all on one shared
// bit-serial divider, then walks the (2r+1)^2 square of offsets with
// r = min(radius / cell_size, 32) at one offset per cycle, set by the
// single read port of the grid memory, and lets the scan pipeline drain.
// It stops early at the first occupied cell found. A query before any load
// answers 0 after the divisions. Configuration is written through
// cfg_valid_i/cfg_ready_o while idle; cfg_ready_o is always high.
module grid_disk_obstacle_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             kind_i,
  input  logic [gdoc_pkg::IndexW-1:0]      cell_index_i,
  input  logic signed [gdoc_pkg::ValW-1:0] cell_value_i,
  input  logic signed [gdoc_pkg::CoordW-1:0] point_x_i,
  input  logic signed [gdoc_pkg::CoordW-1:0] point_y_i,
  input  logic [gdoc_pkg::RadW-1:0]        radius_i,
  // result strobe
  output logic                             result_valid_o,
  output logic                             obstacle_hit_o,
  // configuration channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gdoc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gdoc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import gdoc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDivX = 3'd1;
  localparam logic [2:0] StDivY = 3'd2;
  localparam logic [2:0] StDivR = 3'd3;
  localparam logic [2:0] StScan = 3'd4;

  // configuration registers
  logic [CellW-1:0]         cell_size_q;
  logic signed [CoordW-1:0] org_x_q, org_y_q;
  logic [MapW-1:0]          map_w_q, map_h_q;
  logic [LevelW-1:0]        level_q;
  logic [CellW-1:0]         cs_eff;

  // control
  logic [2:0] state_q, state_d;
  logic       loaded_q, loaded_d;
  logic       div_start_q, div_start_d;
  logic       res_v_q, res_v_d;
  logic       hit_q, hit_d;
  logic       scan_v_q, scan_v_d;
  logic       s1_v_q, s1_v_d;
  logic       s2_v_q, s2_v_d;
  logic       s3_v_q, s3_v_d;
  logic signed [OffsW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [ReachW-1:0]       r_q, r_d;

  // query payload
  logic signed [CoordW-1:0] px_q, py_q;
  logic [RadW-1:0]          rad_q;
  logic [R2W-1:0]           r2_q;
  logic signed [GridW-1:0]  gx_q, gx_d, gy_q, gy_d;

  // scan pipeline payload
  logic signed [MetW-1:0]  s1_ox_q, s1_oy_q;
  logic signed [GridW-1:0] s1_nx_q, s1_ny_q;
  logic [SqW-1:0]          s2_ox2_q, s2_oy2_q;
  logic                    s2_in_q;
  logic [IdxW-1:0]         s2_idx_q;

  logic signed [DivW-1:0]  dist_x, dist_y;
  logic [DivW-1:0]         mag_x, mag_y;
  logic signed [GridW-1:0] q_pos;
  logic [ReachW-1:0]       reach;
  logic signed [OffsW-1:0] r_pos;
  logic                    last_dx, last_dy;
  logic                    nx_in, ny_in;
  logic [SqW:0]            dist2;
  logic                    rd_en;
  logic [ValW-1:0]         rd_data;
  logic                    hit_now, drained, kill;
  logic                    wr_acc, qry_acc, wr_en;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready_o    = 1'b1;
  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_v_q;
  assign obstacle_hit_o = hit_q;

  assign wr_acc  = start_i && !busy_o && (kind_i == KindWrite);
  assign qry_acc = start_i && !busy_o && (kind_i == KindQuery);
  assign wr_en   = wr_acc && (32'(cell_index_i) < 32'(GridCells));

  // a zero cell size acts as one
  assign cs_eff = (cell_size_q == '0) ? CellW'(1) : cell_size_q;

  // ---------------------------------------------------------------
  // Configuration registers: the block has no guard; the user must write them only while the block is idle
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= ResetCellSize;
      org_x_q     <= '0;
      org_y_q     <= '0;
      map_w_q     <= ResetMapDim;
      map_h_q     <= ResetMapDim;
      level_q     <= ResetLevel;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCellSize: cell_size_q <= cfg_data_i[CellW-1:0];
        CfgOriginX:  org_x_q     <= $signed(cfg_data_i[CoordW-1:0]);
        CfgOriginY:  org_y_q     <= $signed(cfg_data_i[CoordW-1:0]);
        CfgMapWidth: map_w_q     <= cfg_data_i[MapW-1:0];
        CfgMapHght:  map_h_q     <= cfg_data_i[MapW-1:0];
        CfgLevel:    level_q     <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Divider operands: magnitudes, sign restored on the quotient
  // ---------------------------------------------------------------
  assign dist_x = DivW'(px_q) - DivW'(org_x_q);
  assign dist_y = DivW'(py_q) - DivW'(org_y_q);
  assign mag_x  = dist_x[DivW-1] ? DivW'(-dist_x) : DivW'(dist_x);
  assign mag_y  = dist_y[DivW-1] ? DivW'(-dist_y) : DivW'(dist_y);

  always_comb begin
    div_req.start   = div_start_q;
    div_req.divisor = cs_eff;
    case (state_q)
      StDivX:  div_req.dividend = mag_x;
      StDivY:  div_req.dividend = mag_y;
      default: div_req.dividend = DivW'(rad_q);
    endcase
  end

  gdoc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q_pos = $signed(GridW'(div_rsp.quotient));
  // saturate the reach at the largest square the scan walks
  assign reach = (div_rsp.quotient > DivW'(MaxReach)) ? ReachW'(MaxReach)
                                                      : ReachW'(div_rsp.quotient);

  // ---------------------------------------------------------------
  // Scan pipeline
  //   scan : offset counter (dx outer, dy inner)
  //   S1   : metric offsets and absolute cell coordinates
  //   S2   : squared offsets, map bounds, row-major index
  //   S3   : disk test, memory read issue
  //   S4   : memory data against the threshold
  // ---------------------------------------------------------------
  assign r_pos   = $signed(OffsW'(r_q));
  assign last_dx = (dx_q == r_pos);
  assign last_dy = (dy_q == r_pos);

  assign nx_in = !s1_nx_q[GridW-1] && (s1_nx_q < $signed(GridW'(map_w_q)));
  assign ny_in = !s1_ny_q[GridW-1] && (s1_ny_q < $signed(GridW'(map_h_q)));

  assign dist2 = (SqW+1)'(s2_ox2_q) + (SqW+1)'(s2_oy2_q);
  assign rd_en = s2_v_q && s2_in_q && (dist2 <= (SqW+1)'(r2_q))
                 && (32'(s2_idx_q) < 32'(GridCells));

  assign hit_now = s3_v_q && ($signed(rd_data) >= $signed(ValW'(level_q)));
  assign drained = !scan_v_q && !s1_v_q && !s2_v_q && !s3_v_q;
  assign kill    = (state_q == StScan) && (hit_now || drained);

  // grid store: loads while idle, query reads while busy, never both
  gdoc_ram #(
    .Width (ValW),
    .Depth (GridCells)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (GridAw'(cell_index_i)),
    .wdata_i (cell_value_i),
    .re_i    (rd_en),
    .raddr_i (GridAw'(s2_idx_q)),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q || wr_acc;
    div_start_d = 1'b0;
    res_v_d     = 1'b0;
    hit_d       = hit_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    r_d         = r_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    scan_v_d    = scan_v_q;

    case (state_q)
      StIdle: begin
        if (qry_acc) begin
          state_d     = StDivX;
          div_start_d = 1'b1;
        end
      end
      StDivX: begin
        if (div_rsp.done) begin
          gx_d        = dist_x[DivW-1] ? -q_pos : q_pos;
          state_d     = StDivY;
          div_start_d = 1'b1;
        end
      end
      StDivY: begin
        if (div_rsp.done) begin
          gy_d        = dist_y[DivW-1] ? -q_pos : q_pos;
          state_d     = StDivR;
          div_start_d = 1'b1;
        end
      end
      StDivR: begin
        if (div_rsp.done) begin
          r_d  = reach;
          dx_d = -$signed(OffsW'(reach));
          dy_d = -$signed(OffsW'(reach));
          if (loaded_q) begin
            state_d  = StScan;
            scan_v_d = 1'b1;
          end else begin
            // no map yet: answer clear
            state_d = StIdle;
            res_v_d = 1'b1;
            hit_d   = 1'b0;
          end
        end
      end
      StScan: begin
        if (kill) begin
          state_d  = StIdle;
          res_v_d  = 1'b1;
          hit_d    = hit_now;
          scan_v_d = 1'b0;
        end else if (scan_v_q) begin
          if (last_dy) begin
            dy_d = -r_pos;
            if (last_dx) begin
              scan_v_d = 1'b0;
            end else begin
              dx_d = dx_q + OffsW'(1);
            end
          end else begin
            dy_d = dy_q + OffsW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // drop everything in flight once the answer is known
  assign s1_v_d = scan_v_q && !kill;
  assign s2_v_d = s1_v_q && !kill;
  assign s3_v_d = rd_en && !kill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      loaded_q    <= 1'b0;
      div_start_q <= 1'b0;
      res_v_q     <= 1'b0;
      scan_v_q    <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      r_q         <= '0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      div_start_q <= div_start_d;
      res_v_q     <= res_v_d;
      scan_v_q    <= scan_v_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      s3_v_q      <= s3_v_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      r_q         <= r_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (qry_acc) begin
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      rad_q <= radius_i;
    end
    r2_q  <= R2W'(rad_q) * R2W'(rad_q);
    hit_q <= hit_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;

    // S1: one multiplier per axis
    s1_ox_q <= $signed(MetW'(dx_q)) * $signed(MetW'({1'b0, cs_eff}));
    s1_oy_q <= $signed(MetW'(dy_q)) * $signed(MetW'({1'b0, cs_eff}));
    s1_nx_q <= gx_q + GridW'(dx_q);
    s1_ny_q <= gy_q + GridW'(dy_q);

    // S2: squares, map bounds and row-major index
    s2_ox2_q <= SqW'($signed(SqW'(s1_ox_q)) * $signed(SqW'(s1_ox_q)));
    s2_oy2_q <= SqW'($signed(SqW'(s1_oy_q)) * $signed(SqW'(s1_oy_q)));
    s2_in_q  <= nx_in && ny_in;
    s2_idx_q <= IdxW'(s1_ny_q[MapW-1:0]) * IdxW'(map_w_q) + IdxW'(s1_nx_q[MapW-1:0]);
  end

endmodule

### design/gdoc_checker.sv
// Port-level checks of grid_disk_obstacle_check, bound to the top level.
// Depends on gdoc_pkg and grid_disk_obstacle_check_assert.svh.
`include "grid_disk_obstacle_check_assert.svh"

module gdoc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic kind_i,
  input logic result_valid_o
);
  import gdoc_pkg::*;

  logic write_beat, query_beat;

  assign write_beat = start_i && !busy_o && (kind_i == KindWrite);
  assign query_beat = start_i && !busy_o && (kind_i == KindQuery);

  // a result beat always closes a busy query
  `GDOC_ASSERT_NOW(a_res_after_busy, result_valid_o, $past(busy_o), "result without query")

  // busy only drops together with the result beat
  `GDOC_ASSERT_NOW(a_busy_fall_res, $fell(busy_o), result_valid_o, "query ended silently")

  // loads complete in the cycle they are taken
  `GDOC_ASSERT_NEXT(a_write_fast, write_beat, !busy_o, "load stalled")

  // a query holds the block and answers later
  `GDOC_ASSERT_NEXT(a_query_busy, query_beat, busy_o && !result_valid_o, "query not held")

endmodule

bind grid_disk_obstacle_check gdoc_checker u_checker (.*);
